>>> design/lcdseq_pkg.sv
// ----------------------------------------------------------------------------
// lcdseq_pkg
// Shared types, codes and the sequencer program for the character LCD
// nibble write sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdseq_pkg;

  // request op codes
  localparam int OpW = 3;
  localparam logic [OpW-1:0] OP_CMD    = 3'd0;
  localparam logic [OpW-1:0] OP_DATA   = 3'd1;
  localparam logic [OpW-1:0] OP_CURSOR = 3'd2;
  localparam logic [OpW-1:0] OP_INIT   = 3'd3;
  localparam logic [OpW-1:0] OP_CLEAR  = 3'd4;

  // configuration register indexes
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_PULSE   = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_CMD_WT  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DATA_WT = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PWR_WT  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CLR_WT  = 3'd4;

  localparam logic [7:0]  PULSE_RST   = 8'd1;
  localparam logic [15:0] CMD_WT_RST  = 16'd2000;
  localparam logic [15:0] DATA_WT_RST = 16'd1000;
  localparam logic [15:0] PWR_WT_RST  = 16'd20000;
  localparam logic [15:0] CLR_WT_RST  = 16'd2000;

  // lcd instruction bytes
  localparam logic [7:0] LCD_FUNC_SET  = 8'h28;
  localparam logic [7:0] LCD_ENTRY     = 8'h06;
  localparam logic [7:0] LCD_CLR_DISP  = 8'h01;
  localparam logic [7:0] LCD_DISP_ON   = 8'h0F;
  localparam logic [7:0] LCD_ROW0_BASE = 8'h80;
  localparam logic [7:0] LCD_ROW1_BASE = 8'hC0;

  // payload widths
  localparam int ValueW  = 8;
  localparam int ColW    = 6;
  localparam int NibbleW = 4;
  localparam int HoldW   = 16;

  // program layout
  localparam int UcAw = 5;
  localparam logic [UcAw-1:0] UC_BYTE  = 5'd0;
  localparam logic [UcAw-1:0] UC_CLEAR = 5'd4;
  localparam logic [UcAw-1:0] UC_INIT  = 5'd9;

  typedef enum logic [2:0] {
    BSEL_REG,
    BSEL_FUNC,
    BSEL_ENTRY,
    BSEL_CLEAR,
    BSEL_DISP
  } byte_sel_t;

  typedef enum logic [1:0] {
    NSEL_HI,
    NSEL_LO,
    NSEL_ZERO,
    NSEL_ONE
  } nib_sel_t;

  typedef enum logic [1:0] {
    HSEL_PULSE,
    HSEL_SETTLE,
    HSEL_POWER,
    HSEL_CLEAR
  } hold_sel_t;

  typedef struct packed {
    byte_sel_t byte_sel;
    nib_sel_t  nib_sel;
    logic      en;
    hold_sel_t hold_sel;
    logic      last;
  } uc_word_t;

  function automatic uc_word_t uc_mk(input byte_sel_t b, input nib_sel_t n,
                                     input logic e, input hold_sel_t h,
                                     input logic l);
    uc_word_t w;
    w.byte_sel = b;
    w.nib_sel  = n;
    w.en       = e;
    w.hold_sel = h;
    w.last     = l;
    return w;
  endfunction

  // sequencer program: byte send, clear, then initialise
  function automatic uc_word_t uc_rom(input logic [UcAw-1:0] addr);
    uc_word_t w;
    unique case (addr)
      // generic byte from the latched byte register
      5'd0:  w = uc_mk(BSEL_REG,   NSEL_HI,   1'b1, HSEL_PULSE,  1'b0);
      5'd1:  w = uc_mk(BSEL_REG,   NSEL_HI,   1'b0, HSEL_SETTLE, 1'b0);
      5'd2:  w = uc_mk(BSEL_REG,   NSEL_LO,   1'b1, HSEL_PULSE,  1'b0);
      5'd3:  w = uc_mk(BSEL_REG,   NSEL_LO,   1'b0, HSEL_SETTLE, 1'b1);
      // clear display
      5'd4:  w = uc_mk(BSEL_CLEAR, NSEL_HI,   1'b1, HSEL_PULSE,  1'b0);
      5'd5:  w = uc_mk(BSEL_CLEAR, NSEL_HI,   1'b0, HSEL_SETTLE, 1'b0);
      5'd6:  w = uc_mk(BSEL_CLEAR, NSEL_LO,   1'b1, HSEL_PULSE,  1'b0);
      5'd7:  w = uc_mk(BSEL_CLEAR, NSEL_LO,   1'b0, HSEL_SETTLE, 1'b0);
      5'd8:  w = uc_mk(BSEL_CLEAR, NSEL_ONE,  1'b0, HSEL_CLEAR,  1'b1);
      // initialise
      5'd9:  w = uc_mk(BSEL_REG,   NSEL_ZERO, 1'b0, HSEL_POWER,  1'b0);
      5'd10: w = uc_mk(BSEL_FUNC,  NSEL_HI,   1'b1, HSEL_PULSE,  1'b0);
      5'd11: w = uc_mk(BSEL_FUNC,  NSEL_HI,   1'b0, HSEL_SETTLE, 1'b0);
      5'd12: w = uc_mk(BSEL_FUNC,  NSEL_LO,   1'b1, HSEL_PULSE,  1'b0);
      5'd13: w = uc_mk(BSEL_FUNC,  NSEL_LO,   1'b0, HSEL_SETTLE, 1'b0);
      5'd14: w = uc_mk(BSEL_ENTRY, NSEL_HI,   1'b1, HSEL_PULSE,  1'b0);
      5'd15: w = uc_mk(BSEL_ENTRY, NSEL_HI,   1'b0, HSEL_SETTLE, 1'b0);
      5'd16: w = uc_mk(BSEL_ENTRY, NSEL_LO,   1'b1, HSEL_PULSE,  1'b0);
      5'd17: w = uc_mk(BSEL_ENTRY, NSEL_LO,   1'b0, HSEL_SETTLE, 1'b0);
      5'd18: w = uc_mk(BSEL_CLEAR, NSEL_HI,   1'b1, HSEL_PULSE,  1'b0);
      5'd19: w = uc_mk(BSEL_CLEAR, NSEL_HI,   1'b0, HSEL_SETTLE, 1'b0);
      5'd20: w = uc_mk(BSEL_CLEAR, NSEL_LO,   1'b1, HSEL_PULSE,  1'b0);
      5'd21: w = uc_mk(BSEL_CLEAR, NSEL_LO,   1'b0, HSEL_SETTLE, 1'b0);
      5'd22: w = uc_mk(BSEL_CLEAR, NSEL_ONE,  1'b0, HSEL_CLEAR,  1'b0);
      5'd23: w = uc_mk(BSEL_DISP,  NSEL_HI,   1'b1, HSEL_PULSE,  1'b0);
      5'd24: w = uc_mk(BSEL_DISP,  NSEL_HI,   1'b0, HSEL_SETTLE, 1'b0);
      5'd25: w = uc_mk(BSEL_DISP,  NSEL_LO,   1'b1, HSEL_PULSE,  1'b0);
      5'd26: w = uc_mk(BSEL_DISP,  NSEL_LO,   1'b0, HSEL_SETTLE, 1'b1);
      default: w = uc_mk(BSEL_REG, NSEL_ZERO, 1'b0, HSEL_PULSE,  1'b1);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> design/lcdseq_if.sv
// ----------------------------------------------------------------------------
// lcdseq_if
// Valid/ready channels: request words in, pin-level item words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdseq_req_if;
  import lcdseq_pkg::*;

  logic              valid;
  logic              ready;
  logic [OpW-1:0]    op;
  logic [ValueW-1:0] value;
  logic              row;
  logic [ColW-1:0]   col;

  modport source (output valid, output op, output value, output row, output col,
                  input ready);
  modport sink   (input valid, input op, input value, input row, input col,
                  output ready);
endinterface

interface lcdseq_item_if;
  import lcdseq_pkg::*;

  logic               valid;
  logic               ready;
  logic               rs;
  logic               en;
  logic [NibbleW-1:0] nibble;
  logic [HoldW-1:0]   hold_us;
  logic               last;

  modport source (output valid, output rs, output en, output nibble, output hold_us,
                  output last, input ready);
  modport sink   (input valid, input rs, input en, input nibble, input hold_us,
                  input last, output ready);
endinterface

`default_nettype wire

>>> design/char_lcd_nibble_write_sequencer.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// A 27-step microprogram emits one item word per cycle while out_item.ready
// is high: 4 for command, data and set cursor, 5 for clear, 18 for initialise.
// A taken request loads busy, pc, rs and, for byte ops, the byte register; no
// request is taken while busy, and busy drops as the last item is registered.
// Reset clears control state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_write_sequencer (
  input  wire                                 clk,
  input  wire                                 rst_n,
  lcdseq_req_if.sink                          in_req,
  lcdseq_item_if.source                       out_item,
  input  wire                                 cfg_we,
  input  wire [lcdseq_pkg::CfgIdxW-1:0]       cfg_idx,
  input  wire [lcdseq_pkg::CfgDataW-1:0]      cfg_data
);
  import lcdseq_pkg::*;

  // configuration
  logic [7:0]       pulse_r;
  logic [HoldW-1:0] cmd_wt_r, data_wt_r, pwr_wt_r, clr_wt_r;

  // sequencer
  logic             busy_r, busy_nxt;
  logic [UcAw-1:0]  pc_r, pc_nxt;
  logic             rs_r, rs_nxt;
  logic [7:0]       byte_r, byte_nxt;

  // output register
  logic               ov_r, ov_nxt;
  logic               ors_r, ors_nxt;
  logic               oen_r, oen_nxt;
  logic [NibbleW-1:0] onib_r, onib_nxt;
  logic [HoldW-1:0]   ohold_r, ohold_nxt;
  logic               olast_r, olast_nxt;

  uc_word_t   cw;
  logic [7:0] cur_byte;
  logic [7:0] row_base;
  logic       accept, advance;

  assign in_req.ready = !busy_r;
  assign accept  = in_req.valid && !busy_r;
  assign advance = busy_r && (!ov_r || out_item.ready);
  assign row_base = in_req.row ? LCD_ROW1_BASE : LCD_ROW0_BASE;

  always_comb begin
    cw = uc_rom(pc_r);

    unique case (cw.byte_sel)
      BSEL_REG:   cur_byte = byte_r;
      BSEL_FUNC:  cur_byte = LCD_FUNC_SET;
      BSEL_ENTRY: cur_byte = LCD_ENTRY;
      BSEL_CLEAR: cur_byte = LCD_CLR_DISP;
      BSEL_DISP:  cur_byte = LCD_DISP_ON;
      default:    cur_byte = byte_r;
    endcase

    busy_nxt  = busy_r;
    pc_nxt    = pc_r;
    rs_nxt    = rs_r;
    byte_nxt  = byte_r;
    ov_nxt    = ov_r && !out_item.ready;
    ors_nxt   = ors_r;
    oen_nxt   = oen_r;
    onib_nxt  = onib_r;
    ohold_nxt = ohold_r;
    olast_nxt = olast_r;

    if (advance) begin
      ov_nxt  = 1'b1;
      ors_nxt = rs_r;
      oen_nxt = cw.en;
      unique case (cw.nib_sel)
        NSEL_HI:   onib_nxt = cur_byte[7:4];
        NSEL_LO:   onib_nxt = cur_byte[3:0];
        NSEL_ZERO: onib_nxt = 4'h0;
        NSEL_ONE:  onib_nxt = 4'h1;
        default:   onib_nxt = 4'h0;
      endcase
      unique case (cw.hold_sel)
        HSEL_PULSE:  ohold_nxt = {8'h00, pulse_r};
        HSEL_SETTLE: ohold_nxt = rs_r ? data_wt_r : cmd_wt_r;
        HSEL_POWER:  ohold_nxt = pwr_wt_r;
        HSEL_CLEAR:  ohold_nxt = clr_wt_r;
        default:     ohold_nxt = {8'h00, pulse_r};
      endcase
      olast_nxt = cw.last;
      pc_nxt    = pc_r + 1'b1;
      if (cw.last) begin
        busy_nxt = 1'b0;
      end
    end

    if (accept) begin
      // unused op codes are taken and dropped
      unique case (in_req.op)
        OP_CMD: begin
          busy_nxt = 1'b1; pc_nxt = UC_BYTE; rs_nxt = 1'b0; byte_nxt = in_req.value;
        end
        OP_DATA: begin
          busy_nxt = 1'b1; pc_nxt = UC_BYTE; rs_nxt = 1'b1; byte_nxt = in_req.value;
        end
        OP_CURSOR: begin
          busy_nxt = 1'b1; pc_nxt = UC_BYTE; rs_nxt = 1'b0;
          byte_nxt = row_base + {2'b00, in_req.col};
        end
        OP_INIT: begin
          busy_nxt = 1'b1; pc_nxt = UC_INIT; rs_nxt = 1'b0;
        end
        OP_CLEAR: begin
          busy_nxt = 1'b1; pc_nxt = UC_CLEAR; rs_nxt = 1'b0;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      ov_r      <= 1'b0;
      pc_r      <= UC_BYTE;
      rs_r      <= 1'b0;
      pulse_r   <= PULSE_RST;
      cmd_wt_r  <= CMD_WT_RST;
      data_wt_r <= DATA_WT_RST;
      pwr_wt_r  <= PWR_WT_RST;
      clr_wt_r  <= CLR_WT_RST;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
      pc_r   <= pc_nxt;
      rs_r   <= rs_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_PULSE:   pulse_r   <= cfg_data[7:0];
          CFG_CMD_WT:  cmd_wt_r  <= cfg_data;
          CFG_DATA_WT: data_wt_r <= cfg_data;
          CFG_PWR_WT:  pwr_wt_r  <= cfg_data;
          CFG_CLR_WT:  clr_wt_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    ors_r   <= ors_nxt;
    oen_r   <= oen_nxt;
    onib_r  <= onib_nxt;
    ohold_r <= ohold_nxt;
    olast_r <= olast_nxt;
  end

  assign out_item.valid   = ov_r;
  assign out_item.rs      = ors_r;
  assign out_item.en      = oen_r;
  assign out_item.nibble  = onib_r;
  assign out_item.hold_us = ohold_r;
  assign out_item.last    = olast_r;

endmodule

`default_nettype wire
